// File: design/high_zcr_ratio_window_core_defines.svh
// Assertion macros used by the high ZCR ratio window top-level design file.
// No dependencies; include by bare file name.
`ifndef HIGH_ZCR_RATIO_WINDOW_CORE_DEFINES_SVH
`define HIGH_ZCR_RATIO_WINDOW_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define HZR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset
`define HZR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HZR_ASSERT(label, clk, rst_n, prop, msg)
`define HZR_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// File: design/hzr_pkg.sv
// Shared constants and types for the high ZCR ratio window core.
// No dependencies.
package hzr_pkg;

    // Field widths
    localparam int ZCR_W   = 17;
    localparam int GAIN_W  = 12;
    localparam int COUNT_W = 6;

    // Default window length
    localparam int HISTORY_DEPTH_DEF = 32;

    // Register and fixed-point constants
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 12'd384;
    localparam logic [ZCR_W-1:0]   ONE_Q16   = 17'd65536;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

    // Control from the sequencer to the counting unit
    typedef struct packed {
        logic clear;
        logic valid;
    } t_cnt_ctrl;

endpackage

// File: design/hzr_cell.sv
// One history entry of the shift chain: holds a rate and passes it on.
// Depends on hzr_pkg.
module hzr_cell #(
    parameter logic [hzr_pkg::ZCR_W-1:0] P_RESET_VAL = '0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_shift,
    input  logic [hzr_pkg::ZCR_W-1:0] i_d,
    output logic [hzr_pkg::ZCR_W-1:0] o_q
);

    logic [hzr_pkg::ZCR_W-1:0] r_val;

    // Take the neighbor's value on every shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= P_RESET_VAL;
        end else if (i_shift) begin
            r_val <= i_d;
        end
    end

    assign o_q = r_val;

endmodule

// File: design/hzr_count.sv
// Counting unit: scales each entry leaving the chain and counts those above the bound.
// Depends on hzr_pkg.
module hzr_count #(
    parameter int HISTORY_DEPTH = hzr_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  hzr_pkg::t_cnt_ctrl                     i_ctrl,
    input  logic [hzr_pkg::ZCR_W-1:0]              i_value,
    input  logic [hzr_pkg::GAIN_W+hzr_pkg::ZCR_W+$clog2(HISTORY_DEPTH)-1:0] i_rhs,
    output logic                                   o_busy,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0]     o_count
);

    localparam int NW = $clog2(HISTORY_DEPTH + 1);
    localparam int PW = hzr_pkg::ZCR_W + NW;
    localparam int LW = PW + 8;
    localparam int RW = hzr_pkg::GAIN_W + hzr_pkg::ZCR_W + $clog2(HISTORY_DEPTH);
    localparam int CW = (LW > RW) ? LW : RW;

    logic          r_prod_vld;
    logic [PW-1:0] r_prod;
    logic [NW-1:0] r_count;
    logic [CW-1:0] w_lhs;
    logic [CW-1:0] w_rhs;

    // Scale the entry by the window length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.valid) begin
            r_prod <= PW'(i_value) * PW'(HISTORY_DEPTH);
        end
    end

    // Compare value*N*256 against gain*sum
    assign w_lhs = CW'({r_prod, 8'b0});
    assign w_rhs = CW'(i_rhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.clear) begin
            r_count <= '0;
        end else if (r_prod_vld && (w_lhs > w_rhs)) begin
            r_count <= r_count + NW'(1);
        end
    end

    assign o_busy  = r_prod_vld;
    assign o_count = r_count;

endmodule

// File: design/high_zcr_ratio_window_core.sv
// Top level of the high ZCR ratio window core: shift chain, running sum, sequencer.
// Depends on hzr_pkg, hzr_cell, hzr_count and high_zcr_ratio_window_core_defines.svh.
//
//  Port group      Dir  Beat contents
//  s_axis_*        in   one frame rate (tdata) and nonempty flag (tuser)
//  m_axis_*        out  count of history entries above the bound (tdata)
//  i_cfg_wr_*      in   bound gain register write, no read-back
//
// A frame with samples passes through S_MUL, S_SCAN, S_DRAIN and S_DONE: the
// scan rotates the cell chain once past a single scaling multiplier and comparator.
// An empty frame goes straight from S_IDLE to S_DONE and returns the last count.
// A new beat is accepted while the previous result still waits on m_axis_tready.
// Reset is synchronous, active low, and loads the history pattern.
`include "high_zcr_ratio_window_core_defines.svh"

module high_zcr_ratio_window_core #(
    parameter int HISTORY_DEPTH = hzr_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // slave side
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [23:0]                s_axis_tdata,  // [16:0] frame_zcr
    input  logic                       s_axis_tuser,  // [0] has_samples
    // master side
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // [5:0] high_count
    // configuration
    input  logic                       i_cfg_wr_en,
    input  logic [hzr_pkg::GAIN_W-1:0] i_cfg_wr_data
);

    localparam int ZW  = hzr_pkg::ZCR_W;
    localparam int SW  = ZW + $clog2(HISTORY_DEPTH);
    localparam int RW  = hzr_pkg::GAIN_W + SW;
    localparam int NW  = $clog2(HISTORY_DEPTH + 1);
    localparam int SCW = $clog2(HISTORY_DEPTH);
    localparam logic [SW-1:0] SUM_RST = SW'((HISTORY_DEPTH / 2) * 65536);
    localparam logic [hzr_pkg::COUNT_W-1:0] LAST_RST =
        ((HISTORY_DEPTH / 2) > 63) ? hzr_pkg::COUNT_MAX
                                   : hzr_pkg::COUNT_W'(HISTORY_DEPTH / 2);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                        r_state, n_state;
    logic [SW-1:0]                 r_sum;
    logic [RW-1:0]                 r_rhs;
    logic [hzr_pkg::GAIN_W-1:0]    r_gain;
    logic [SCW-1:0]                r_scan_cnt;
    logic [hzr_pkg::COUNT_W-1:0]   r_last_count, n_last_count;
    logic                          r_out_valid;
    logic [hzr_pkg::COUNT_W-1:0]   r_out_count;

    logic                          w_accept;
    logic                          w_push;
    logic                          w_shift;
    logic [ZW-1:0]                 w_feed;
    logic [ZW-1:0]                 w_q [HISTORY_DEPTH];
    logic [ZW-1:0]                 w_tail;
    logic                          w_out_free;
    hzr_pkg::t_cnt_ctrl            w_cnt_ctrl;
    logic                          w_cnt_busy;
    logic [NW-1:0]                 w_cnt;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_push        = w_accept && s_axis_tuser;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_tail        = w_q[HISTORY_DEPTH-1];

    // Push a new rate, or rotate the chain during the scan
    assign w_shift = w_push || (r_state == S_SCAN);
    assign w_feed  = (r_state == S_SCAN) ? w_tail : s_axis_tdata[ZW-1:0];

    // Cell k holds the entry k+1 writes behind the next write slot
    for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
        localparam logic [ZW-1:0] CELL_RST =
            (((HISTORY_DEPTH - 1 - k) % 2) == 1) ? hzr_pkg::ONE_Q16 : '0;
        hzr_cell #(
            .P_RESET_VAL (CELL_RST)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_d     ((k == 0) ? w_feed : w_q[(k == 0) ? 0 : k-1]),
            .o_q     (w_q[k])
        );
    end

    // Count entries as they leave the tail of the chain
    assign w_cnt_ctrl.clear = (r_state == S_MUL);
    assign w_cnt_ctrl.valid = (r_state == S_SCAN);

    hzr_count #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_cnt_ctrl),
        .i_value (w_tail),
        .i_rhs   (r_rhs),
        .o_busy  (w_cnt_busy),
        .o_count (w_cnt)
    );

    // Hold the bound gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= hzr_pkg::GAIN_RST;
        end else if (i_cfg_wr_en) begin
            r_gain <= i_cfg_wr_data;
        end
    end

    // Keep the window sum: add the new rate, drop the overwritten one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= SUM_RST;
        end else if (w_push) begin
            r_sum <= r_sum - SW'(w_tail) + SW'(s_axis_tdata[ZW-1:0]);
        end
    end

    // Form gain * sum once per frame with samples
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_rhs <= RW'(r_gain) * RW'(r_sum);
        end
    end

    // Advance the scan position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
        end else if (r_state == S_SCAN) begin
            r_scan_cnt <= (r_scan_cnt == SCW'(HISTORY_DEPTH - 1)) ? '0
                                                                  : r_scan_cnt + SCW'(1);
        end
    end

    // Saturate the count into the result field
    always_comb begin
        if (32'(w_cnt) > 32'(hzr_pkg::COUNT_MAX)) begin
            n_last_count = hzr_pkg::COUNT_MAX;
        end else begin
            n_last_count = hzr_pkg::COUNT_W'(w_cnt);
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = s_axis_tuser ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_scan_cnt == SCW'(HISTORY_DEPTH - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!w_cnt_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch the finished count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_count <= LAST_RST;
        end else if ((r_state == S_DRAIN) && !w_cnt_busy) begin
            r_last_count <= n_last_count;
        end
    end

    // Output register: load when the slot is free, drop valid on handoff
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_count <= r_last_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_count};

    // Checks
    `HZR_ASSERT(a_empty_frame_to_done, i_clk, i_rst_n, (w_accept && !s_axis_tuser) |=> (r_state == S_DONE), "empty frame did not go straight to result")
    `HZR_ASSERT(a_result_after_done, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> ($past(r_state) == S_DONE), "result raised outside the done state")
    `HZR_ASSERT_NEVER(a_count_idle_busy, i_clk, i_rst_n, (r_state == S_IDLE) && w_cnt_busy, "counting unit busy while idle")
    `HZR_ASSERT(a_scan_starts_at_zero, i_clk, i_rst_n, (r_state == S_MUL) |-> (r_scan_cnt == '0), "scan position not at zero before scan")

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench for high_zcr_ratio_window_core: random frame rates with idle gaps and stalls,
// checked beat by beat against a sliding-window count predictor. Depends on hzr_pkg and the core.

module tb;

    localparam int DEPTH       = hzr_pkg::HISTORY_DEPTH_DEF;
    localparam int ZW          = hzr_pkg::ZCR_W;
    localparam int GW          = hzr_pkg::GAIN_W;
    localparam int CNTW        = hzr_pkg::COUNT_W;
    localparam int IDLE_MAX    = 16;
    localparam int DRAIN_WAIT  = DEPTH + 8;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [ZW-1:0] zcr;
        logic          has;
        int unsigned   gap;
    } t_frame_item;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [23:0]        s_axis_tdata = '0;   // [16:0] frame_zcr
    logic               s_axis_tuser = 1'b0; // [0] has_samples
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;        // [5:0] high_count
    logic               i_cfg_wr_en = 1'b0;
    logic [GW-1:0]      i_cfg_wr_data = '0;

    // Predictor state
    logic [ZW-1:0]      zcr_hist [DEPTH];
    int unsigned        wr_slot;
    logic [CNTW-1:0]    held_count;
    logic [GW-1:0]      gain_reg;

    t_frame_item        frame_q [$];
    logic [CNTW-1:0]    count_q [$];

    int unsigned cycle_count = 0;
    int unsigned err_count = 0;
    int unsigned n_frames = 0;
    int unsigned n_empty = 0;
    int unsigned n_results = 0;
    int unsigned n_gains = 1;
    int unsigned tx_gap_left = 0;
    int unsigned rx_hold = 0;
    bit          rx_no_stall = 1'b0;

    high_zcr_ratio_window_core #(
        .HISTORY_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

    // Window count after one frame; an empty frame repeats the held count
    function automatic logic [CNTW-1:0] window_high_count(logic [ZW-1:0] zcr, logic has);
        logic [31:0] win_sum;
        logic [63:0] bound;
        logic [63:0] scaled;
        int unsigned n;
        if (has) begin
            zcr_hist[wr_slot] = zcr;
            win_sum = '0;
            for (int i = 0; i < DEPTH; i++) begin
                win_sum += 32'(zcr_hist[i]);
            end
            bound = 64'(gain_reg) * 64'(win_sum);
            n = 0;
            for (int i = 0; i < DEPTH; i++) begin
                scaled = 64'(zcr_hist[i]) * 64'(DEPTH) * 64'd256;
                if (scaled > bound) begin
                    n++;
                end
            end
            wr_slot = (wr_slot + 1) % DEPTH;
            held_count = (n > hzr_pkg::COUNT_MAX) ? hzr_pkg::COUNT_MAX : CNTW'(n);
        end
        return held_count;
    endfunction

    function automatic int unsigned draw_gap(bit no_idle);
        return no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    // Driver: predict on each accepted beat, then present the next one after its gap
    always @(posedge i_clk) begin
        t_frame_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                count_q.push_back(window_high_count(s_axis_tdata[ZW-1:0], s_axis_tuser));
                if (s_axis_tuser) n_frames++;
                else n_empty++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (frame_q.size() > 0) begin
                    it = frame_q.pop_front();
                    s_axis_tdata  <= 24'(it.zcr);
                    s_axis_tuser  <= it.has;
                    s_axis_tvalid <= 1'b1;
                    tx_gap_left = it.gap;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest predicted count
    always @(posedge i_clk) begin
        logic [CNTW-1:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (count_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d",
                             $time, m_axis_tdata);
                    err_count++;
                end else begin
                    want = count_q.pop_front();
                    if (m_axis_tdata !== {2'b00, want}) begin
                        $display("%0t: high_count mismatch, expected %0d, got %0d",
                                 $time, want, m_axis_tdata);
                        err_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0) rx_no_stall = ~rx_no_stall;
                rx_hold = draw_gap(rx_no_stall);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            m_axis_tready <= (rx_hold == 0);
        end
    end

    task automatic reset_predictor();
        for (int i = 0; i < DEPTH; i++) begin
            zcr_hist[i] = (i % 2 == 1) ? hzr_pkg::ONE_Q16 : '0;
        end
        wr_slot = 0;
        held_count = CNTW'(DEPTH / 2);
        gain_reg = hzr_pkg::GAIN_RST;
    endtask

    // Hold until every beat is sent and every result is back
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (frame_q.size() > 0 || s_axis_tvalid || count_q.size() > 0);
    endtask

    task automatic write_gain(logic [GW-1:0] value);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        gain_reg = value;
        n_gains++;
    endtask

    task automatic add_frame(logic [ZW-1:0] zcr, logic has, bit no_idle);
        t_frame_item it;
        it.zcr = zcr;
        it.has = has;
        it.gap = draw_gap(no_idle);
        frame_q.push_back(it);
    endtask

    // Random frames: mostly rates clustered near a base, with spikes, wide values and empties
    task automatic add_random_frames(int unsigned count);
        int unsigned base;
        int unsigned pick;
        bit no_idle;
        logic [ZW-1:0] zcr;
        base = $urandom_range(0, 40000);
        no_idle = 1'b0;
        for (int k = 0; k < count; k++) begin
            if (k % 50 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 1)) base = $urandom_range(0, 40000);
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                add_frame(ZW'($urandom_range(0, 131071)), 1'b0, no_idle);
            end else begin
                if (pick < 15) begin
                    case ($urandom_range(0, 2))
                        0: zcr = '0;
                        1: zcr = hzr_pkg::ONE_Q16;
                        default: zcr = '1;
                    endcase
                end else if (pick < 25) begin
                    zcr = ZW'($urandom_range(0, 131071));
                end else if (pick < 40) begin
                    zcr = ZW'($urandom_range(0, 65536));
                end else begin
                    zcr = ZW'(base + $urandom_range(0, 4000));
                end
                add_frame(zcr, 1'b1, no_idle);
            end
        end
    endtask

    initial begin
        reset_predictor();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty frames, rate extremes, rates above 1.0, reset gain
        add_frame('1, 1'b0, 1'b0);
        add_frame('0, 1'b1, 1'b0);
        add_frame(hzr_pkg::ONE_Q16, 1'b1, 1'b0);
        add_frame('1, 1'b1, 1'b0);
        add_frame('0, 1'b0, 1'b0);
        add_frame(17'd1, 1'b1, 1'b0);
        for (int k = 0; k < 3; k++) add_frame('1, 1'b1, 1'b1);
        add_frame(hzr_pkg::ONE_Q16, 1'b0, 1'b0);
        for (int k = 0; k < 3; k++) add_frame('0, 1'b1, 1'b0);
        add_frame(17'd65535, 1'b1, 1'b0);
        add_frame(17'd32768, 1'b1, 1'b0);
        add_frame(17'd131070, 1'b1, 1'b1);
        add_frame(17'h0AAAA, 1'b1, 1'b0);
        add_frame(17'h15555, 1'b1, 1'b0);
        add_random_frames(280);

        // Gain extremes, unity, then random settings
        write_gain('0);
        add_frame('0, 1'b1, 1'b0);
        add_frame('0, 1'b0, 1'b0);
        add_random_frames(250);
        write_gain('1);
        add_frame('1, 1'b1, 1'b0);
        add_random_frames(250);
        write_gain(12'd256);
        add_random_frames(250);
        for (int p = 0; p < 3; p++) begin
            write_gain(GW'($urandom_range(0, 4095)));
            add_random_frames(250);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Covered %0d frames with samples and %0d empty frames under %0d gain settings,",
                 n_frames, n_empty, n_gains);
        $display("with %0d results checked and %0d errors.", n_results, err_count);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
